// File: rtl/rtpg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rtpg_pkg;

    localparam int DEF_COORD_BITS = 12;
    localparam int PHASE_W = 12;
    localparam int SIZE_W = 13;
    localparam int MODE_W = 3;
    localparam int RGB_W = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_H_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_V_OFFSET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FG_RGB = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd6;

    localparam logic [MODE_W-1:0] MODE_SOLID = 3'd0;
    localparam logic [MODE_W-1:0] MODE_VLINES = 3'd1;
    localparam logic [MODE_W-1:0] MODE_HLINES = 3'd2;
    localparam logic [MODE_W-1:0] MODE_XHATCH = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DOTS = 3'd4;
    localparam logic [MODE_W-1:0] MODE_DIAG = 3'd5;

    localparam logic [MODE_W-1:0] RST_MODE = MODE_XHATCH;
    localparam logic [PHASE_W-1:0] RST_PITCH = 12'd32;
    localparam logic [RGB_W-1:0] RST_FG_RGB = 24'hFF0000;
    localparam logic [SIZE_W-1:0] RST_WIDTH = 13'd640;
    localparam logic [SIZE_W-1:0] RST_HEIGHT = 13'd480;

    typedef struct packed {
        logic [PHASE_W-1:0] col_phase;
        logic [PHASE_W-1:0] row_phase;
        logic [PHASE_W-1:0] sum_phase;
        logic [PHASE_W-1:0] diff_phase;
        logic               last_col;
        logic               last_row;
    } t_pos;

    typedef struct packed {
        logic [RGB_W-1:0] rgb;
        logic             lit;
        logic             line_end;
        logic             frame_end;
    } t_result;

    function automatic logic [PHASE_W-1:0] eff_pitch(input logic [PHASE_W-1:0] p);
        return (p == '0) ? PHASE_W'(1) : p;
    endfunction

    function automatic logic [PHASE_W-1:0] phase_up(input logic [PHASE_W-1:0] ph,
                                                    input logic [PHASE_W-1:0] p);
        logic [PHASE_W:0] s;
        s = {1'b0, ph} + (PHASE_W+1)'(1);
        return (s >= {1'b0, p}) ? '0 : s[PHASE_W-1:0];
    endfunction

    function automatic logic [PHASE_W-1:0] phase_down(input logic [PHASE_W-1:0] ph,
                                                      input logic [PHASE_W-1:0] p);
        return ((ph == '0) || (ph >= p)) ? (p - PHASE_W'(1)) : (ph - PHASE_W'(1));
    endfunction

endpackage

`default_nettype wire

// File: rtl/rtpg_raster.sv
`timescale 1ns / 1ps
`default_nettype none

module rtpg_raster #(
    parameter int COORD_BITS = rtpg_pkg::DEF_COORD_BITS
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_advance,
    input  wire                              i_restart,
    input  wire [rtpg_pkg::PHASE_W-1:0]      i_pitch,
    input  wire [rtpg_pkg::SIZE_W-1:0]       i_frame_width,
    input  wire [rtpg_pkg::SIZE_W-1:0]       i_frame_height,
    output rtpg_pkg::t_pos                   o_pos
);
    import rtpg_pkg::*;

    localparam int CMP_W = (COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W;

    logic [COORD_BITS-1:0] r_col, n_col, r_row, n_row;
    logic [PHASE_W-1:0]    r_col_ph, n_col_ph, r_row_ph, n_row_ph;
    logic [PHASE_W-1:0]    r_sum_ph, n_sum_ph, r_diff_ph, n_diff_ph;
    logic [PHASE_W-1:0]    r_rds, n_rds;

    logic [COORD_BITS-1:0] w_col, w_row;
    logic [PHASE_W-1:0]    w_col_ph, w_row_ph, w_sum_ph, w_diff_ph, w_rds;
    logic [PHASE_W-1:0]    w_p, w_row_ph_up, w_rds_dn;
    logic [SIZE_W-1:0]     w_wlim, w_hlim;
    logic                  w_last_col, w_last_row;

    always_comb begin
        w_col     = i_restart ? '0 : r_col;
        w_row     = i_restart ? '0 : r_row;
        w_col_ph  = i_restart ? '0 : r_col_ph;
        w_row_ph  = i_restart ? '0 : r_row_ph;
        w_sum_ph  = i_restart ? '0 : r_sum_ph;
        w_diff_ph = i_restart ? '0 : r_diff_ph;
        w_rds     = i_restart ? '0 : r_rds;
        w_p       = eff_pitch(i_pitch);
        w_wlim    = i_frame_width - SIZE_W'(1);
        w_hlim    = i_frame_height - SIZE_W'(1);
        w_last_col = (CMP_W'(w_col) == CMP_W'(w_wlim)) || (&w_col);
        w_last_row = (CMP_W'(w_row) == CMP_W'(w_hlim)) || (&w_row);
        w_row_ph_up = phase_up(w_row_ph, w_p);
        w_rds_dn    = phase_down(w_rds, w_p);
    end

    always_comb begin
        o_pos.col_phase  = w_col_ph;
        o_pos.row_phase  = w_row_ph;
        o_pos.sum_phase  = w_sum_ph;
        o_pos.diff_phase = w_diff_ph;
        o_pos.last_col   = w_last_col;
        o_pos.last_row   = w_last_row;
    end

    always_comb begin
        n_col     = w_col;
        n_row     = w_row;
        n_col_ph  = w_col_ph;
        n_row_ph  = w_row_ph;
        n_sum_ph  = w_sum_ph;
        n_diff_ph = w_diff_ph;
        n_rds     = w_rds;
        priority if (!w_last_col) begin
            n_col     = w_col + COORD_BITS'(1);
            n_col_ph  = phase_up(w_col_ph, w_p);
            n_sum_ph  = phase_up(w_sum_ph, w_p);
            n_diff_ph = phase_up(w_diff_ph, w_p);
        end else if (w_last_row) begin
            n_col     = '0;
            n_row     = '0;
            n_col_ph  = '0;
            n_row_ph  = '0;
            n_sum_ph  = '0;
            n_diff_ph = '0;
            n_rds     = '0;
        end else begin
            n_col     = '0;
            n_col_ph  = '0;
            n_row     = w_row + COORD_BITS'(1);
            n_row_ph  = w_row_ph_up;
            n_rds     = w_rds_dn;
            n_sum_ph  = w_row_ph_up;
            n_diff_ph = w_rds_dn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_col_ph  <= '0;
            r_row_ph  <= '0;
            r_sum_ph  <= '0;
            r_diff_ph <= '0;
            r_rds     <= '0;
        end else if (i_advance) begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_col_ph  <= n_col_ph;
            r_row_ph  <= n_row_ph;
            r_sum_ph  <= n_sum_ph;
            r_diff_ph <= n_diff_ph;
            r_rds     <= n_rds;
        end
    end

endmodule

`default_nettype wire

// File: rtl/rtpg_pattern.sv
`timescale 1ns / 1ps
`default_nettype none

module rtpg_pattern (
    input  wire rtpg_pkg::t_pos             i_pos,
    input  wire [rtpg_pkg::MODE_W-1:0]      i_mode,
    input  wire [rtpg_pkg::PHASE_W-1:0]     i_pitch,
    input  wire [rtpg_pkg::PHASE_W-1:0]     i_h_offset,
    input  wire [rtpg_pkg::PHASE_W-1:0]     i_v_offset,
    input  wire [rtpg_pkg::RGB_W-1:0]       i_fg_rgb,
    output rtpg_pkg::t_result               o_result
);
    import rtpg_pkg::*;

    logic [PHASE_W-1:0] w_p, w_st, w_dt;
    logic [PHASE_W:0]   w_sum, w_sum_red, w_dt_full;
    logic               w_h_ok, w_v_ok, w_vl, w_hl, w_dg, w_lit;

    always_comb begin
        w_p    = eff_pitch(i_pitch);
        w_h_ok = i_h_offset < w_p;
        w_v_ok = i_v_offset < w_p;

        w_sum     = {1'b0, i_h_offset} + {1'b0, i_v_offset};
        w_sum_red = (w_sum >= {1'b0, w_p}) ? (w_sum - {1'b0, w_p}) : w_sum;
        w_st      = w_sum_red[PHASE_W-1:0];
        w_dt_full = (i_h_offset >= i_v_offset)
                  ? ({1'b0, i_h_offset} - {1'b0, i_v_offset})
                  : ({1'b0, i_h_offset} + {1'b0, w_p} - {1'b0, i_v_offset});
        w_dt      = w_dt_full[PHASE_W-1:0];

        w_vl = w_h_ok && (i_pos.col_phase == i_h_offset);
        w_hl = w_v_ok && (i_pos.row_phase == i_v_offset);
        w_dg = w_h_ok && w_v_ok &&
               ((i_pos.sum_phase == w_st) || (i_pos.diff_phase == w_dt));

        unique case (i_mode)
            MODE_SOLID:  w_lit = 1'b1;
            MODE_VLINES: w_lit = w_vl;
            MODE_HLINES: w_lit = w_hl;
            MODE_XHATCH: w_lit = w_vl || w_hl;
            MODE_DOTS:   w_lit = w_vl && w_hl;
            MODE_DIAG:   w_lit = w_dg;
            default:     w_lit = 1'b0;
        endcase

        o_result.rgb       = w_lit ? i_fg_rgb : '0;
        o_result.lit       = w_lit;
        o_result.line_end  = i_pos.last_col;
        o_result.frame_end = i_pos.last_col && i_pos.last_row;
    end

endmodule

`default_nettype wire

// File: rtl/raster_test_pattern_generator.sv
// Raster test pattern generator.
// Input channel (i_valid / o_stall): each item is one pixel clock tick;
// i_restart_frame set restarts at pixel 0,0, clear takes the next pixel.
// Output channel (o_valid / i_stall): one pixel per input item, in raster
// order, with its color, lit flag, and line/frame end markers.
// Each accepted pixel goes to the output register, or to the skid register.
// Throughput: 1 item per cycle while the receiver takes results; the pixel is
// computed in one pass from the raster and phase counters into the register.
// When the receiver stalls, one further item is taken into a skid register,
// then o_stall rises until the output register drains.
// Configuration: i_cfg_wr_en writes i_cfg_wr_data into register
// i_cfg_index (mode, pitch, offsets, color, width, height); change it only
// when no item is in flight. Changes apply from the next pixel.
// Reset (synchronous, active low): registers return to crosshatch, pitch 32,
// red, 640x480; counters go to pixel 0,0; both output slots empty.
`timescale 1ns / 1ps
`default_nettype none

module raster_test_pattern_generator #(
    parameter int COORD_BITS = rtpg_pkg::DEF_COORD_BITS
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_wr_en,
    input  wire [rtpg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire [rtpg_pkg::CFG_DATA_W-1:0]    i_cfg_wr_data,
    input  wire                               i_valid,
    output logic                              o_stall,
    input  wire                               i_restart_frame,
    output logic                              o_valid,
    input  wire                               i_stall,
    output logic [rtpg_pkg::RGB_W-1:0]        o_pixel_rgb,
    output logic                              o_pixel_lit,
    output logic                              o_line_end,
    output logic                              o_frame_end
);
    import rtpg_pkg::*;

    logic [MODE_W-1:0]  r_mode;
    logic [PHASE_W-1:0] r_pitch, r_h_off, r_v_off;
    logic [RGB_W-1:0]   r_fg;
    logic [SIZE_W-1:0]  r_width, r_height;

    t_pos    w_pos;
    t_result w_result;
    t_result r_out, r_skid;
    logic    r_out_valid, r_skid_valid;
    logic    w_accept, w_take, w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= RST_MODE;
            r_pitch  <= RST_PITCH;
            r_h_off  <= '0;
            r_v_off  <= '0;
            r_fg     <= RST_FG_RGB;
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_PATTERN_MODE: r_mode   <= i_cfg_wr_data[MODE_W-1:0];
                REG_LINE_PITCH:   r_pitch  <= i_cfg_wr_data[PHASE_W-1:0];
                REG_H_OFFSET:     r_h_off  <= i_cfg_wr_data[PHASE_W-1:0];
                REG_V_OFFSET:     r_v_off  <= i_cfg_wr_data[PHASE_W-1:0];
                REG_FG_RGB:       r_fg     <= i_cfg_wr_data[RGB_W-1:0];
                REG_FRAME_WIDTH:  r_width  <= i_cfg_wr_data[SIZE_W-1:0];
                REG_FRAME_HEIGHT: r_height <= i_cfg_wr_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_stall    = r_skid_valid;
    assign w_accept   = i_valid && !r_skid_valid;
    assign w_take     = r_out_valid && !i_stall;
    assign w_out_free = !r_out_valid || w_take;

    rtpg_raster #(
        .COORD_BITS(COORD_BITS)
    ) u_raster (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (w_accept),
        .i_restart      (i_restart_frame),
        .i_pitch        (r_pitch),
        .i_frame_width  (r_width),
        .i_frame_height (r_height),
        .o_pos          (w_pos)
    );

    rtpg_pattern u_pattern (
        .i_pos      (w_pos),
        .i_mode     (r_mode),
        .i_pitch    (r_pitch),
        .i_h_offset (r_h_off),
        .i_v_offset (r_v_off),
        .i_fg_rgb   (r_fg),
        .o_result   (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid  <= r_skid_valid || w_accept;
            r_skid_valid <= 1'b0;
        end else if (w_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out <= r_skid_valid ? r_skid : w_result;
        end else if (w_accept) begin
            r_skid <= w_result;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_pixel_rgb = r_out.rgb;
    assign o_pixel_lit = r_out.lit;
    assign o_line_end  = r_out.line_end;
    assign o_frame_end = r_out.frame_end;

`ifndef NO_ASSERTIONS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds an item while output register is empty");

    a_frame_end_line_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_end) |-> o_line_end)
        else $error("frame end without line end");

    a_dark_is_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_pixel_lit) |-> (o_pixel_rgb == '0))
        else $error("unlit pixel carries color");

    a_skid_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall && w_accept) |=> (r_skid_valid && r_out_valid))
        else $error("item accepted under stall was not kept in skid");
`endif

endmodule

`default_nettype wire
